FILE: design/fr_pkg.sv
// ----------------------------------------------------------------------------
// fr_pkg
// Shared widths and types for the footprint radius block.
// ----------------------------------------------------------------------------
package fr_pkg;

  // Coordinate format: signed fixed point with ten fraction bits.
  localparam int COORD_W = 16;
  localparam int OUT_W   = 16;
  localparam int AREA_W  = 40;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 34;
  localparam int NORM_W  = 32;
  localparam int PROD_W  = NUM_W + DEN_W;
  localparam int CNT_W   = 7;

  // Number of vertices needed for a valid polygon.
  localparam logic [1:0] MIN_VERTS = 2'd3;

  // One vertex item as it travels from the front queue to the engine.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } vert_t;

endpackage

FILE: design/footprint_radii_top.sv
// ----------------------------------------------------------------------------
// footprint_radii_top
// Inscribed and circumscribed radius of a streamed footprint polygon.
// ----------------------------------------------------------------------------
// Each vertex's time goes mostly to the bit-serial fraction compare of its edge.
// A last vertex adds its closing edge and then root, divide and root, the divide
// and second root only when an inscribed radius is valid. A first vertex that is
// not last has no edge. The engine takes a new vertex only when done with the
// previous one; a four-entry queue buffers input.
// Synchronous active-low reset empties queue and output and clears polygon state.
// ----------------------------------------------------------------------------
module footprint_radii_top
  import fr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic signed [COORD_W-1:0] in_vertex_x,
  input  logic signed [COORD_W-1:0] in_vertex_y,
  input  logic                      in_last_vertex,
  output logic                      empty,
  input  logic                      pop,
  output logic [OUT_W-1:0]          out_inscribed,
  output logic [OUT_W-1:0]          out_circumscribed,
  output logic                      out_inscribed_valid,
  output logic                      out_circumscribed_valid
);

  vert_t push_item, q_item;
  logic  q_empty, q_pop;

  assign push_item.x    = in_vertex_x;
  assign push_item.y    = in_vertex_y;
  assign push_item.last = in_last_vertex;

  // Front queue of vertex items.
  fr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .push_item (push_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // Back end geometry engine with its result register.
  fr_engine u_engine (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_empty                 (q_empty),
    .q_pop                   (q_pop),
    .q_item                  (q_item),
    .empty                   (empty),
    .pop                     (pop),
    .out_inscribed           (out_inscribed),
    .out_circumscribed       (out_circumscribed),
    .out_inscribed_valid     (out_inscribed_valid),
    .out_circumscribed_valid (out_circumscribed_valid)
  );

endmodule

FILE: design/fr_front.sv
// ----------------------------------------------------------------------------
// fr_front
// Input queue: takes vertex items and holds them until the engine pops them.
// ----------------------------------------------------------------------------
module fr_front
  import fr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  vert_t push_item,
  output logic  q_empty,
  input  logic  q_pop,
  output vert_t q_item
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  vert_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]    count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign q_empty = (count_r == '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && !q_empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(do_pop);
    count_nxt  = count_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: design/fr_engine.sv
// ----------------------------------------------------------------------------
// fr_engine
// Back end: folds each vertex into the polygon state and, on the last vertex,
// produces both radii through a serial divider and a serial square root.
// ----------------------------------------------------------------------------
module fr_engine
  import fr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  vert_t               q_item,
  output logic                empty,
  input  logic                pop,
  output logic [OUT_W-1:0]    out_inscribed,
  output logic [OUT_W-1:0]    out_circumscribed,
  output logic                out_inscribed_valid,
  output logic                out_circumscribed_valid
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_E1   = 4'd2;
  localparam logic [3:0] S_E2   = 4'd3;
  localparam logic [3:0] S_E3   = 4'd4;
  localparam logic [3:0] S_E4   = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_r;

  // Current item and polygon state.
  logic signed [COORD_W-1:0] vx_r, vy_r;
  logic                      vl_r;
  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [1:0]                seen_r;
  logic [AREA_W-1:0]         area_r;
  logic                      par_r, onedge_r;
  logic [NUM_W-1:0]          best_num_r;
  logic [DEN_W-1:0]          best_den_r;
  logic [NORM_W-1:0]         maxn_r;

  // Edge pipeline.
  logic                      close_r;
  logic signed [COORD_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [31:0]        p1_r, p2_r;
  logic signed [COORD_W:0]   dx_r, dy_r;
  logic signed [32:0]        cross_r;
  logic signed [32:0]        q1_r, q2_r;
  logic signed [33:0]        s1_r, s2_r;
  logic [NORM_W-1:0]         va_r, vb_r;
  logic [NUM_W-1:0]          cr2_r;
  logic signed [34:0]        proj_r;
  logic [DEN_W-1:0]          len2_r;
  logic [NUM_W-1:0]          num_r;
  logic [DEN_W-1:0]          den_r;

  // Serial fraction compare: num * best_den against best_num * den.
  logic [PROD_W-1:0]         mca_r, mcb_r, acca_r, accb_r;
  logic [DEN_W-1:0]          mpa_r, mpb_r;
  logic [CNT_W-1:0]          cnt_r;

  // Serial divider and square root.
  logic [DEN_W:0]            rem_r;
  logic [NUM_W-1:0]          quo_r;
  logic [NUM_W-1:0]          sv_r, sr_r, sb_r;
  logic                      sq_ins_r;
  logic                      ins_ok_r, circ_ok_r;
  logic [OUT_W-1:0]          circ_res_r;

  // Output register.
  logic                      out_valid_r;
  logic [OUT_W-1:0]          out_ins_r, out_circ_r;
  logic                      out_insv_r, out_circv_r;

  // Combinational helpers.
  logic signed [32:0]        va_full, vb_full;
  logic signed [32:0]        cross_abs;
  logic signed [33:0]        qsum;
  logic [AREA_W-1:0]         cross_ext;
  logic                      on_edge_hit, par_hit;
  logic [NUM_W-1:0]          sel_num;
  logic [DEN_W-1:0]          sel_den;
  logic [DEN_W:0]            div_t;
  logic [NUM_W-1:0]          sq_sum;
  logic [NORM_W-1:0]         n2_cur;
  logic signed [32:0]        n2_full;

  assign q_pop                  = (state_r == S_IDLE) && !q_empty;
  assign empty                  = !out_valid_r;
  assign out_inscribed          = out_ins_r;
  assign out_circumscribed      = out_circ_r;
  assign out_inscribed_valid    = out_insv_r;
  assign out_circumscribed_valid = out_circv_r;

  // Squared norm of the current vertex.
  assign n2_full = vx_r * vx_r + vy_r * vy_r;
  assign n2_cur  = n2_full[NORM_W-1:0];

  // Endpoint norms of the edge.
  assign va_full = ax_r * ax_r + ay_r * ay_r;
  assign vb_full = bx_r * bx_r + by_r * by_r;

  // Edge classification from the cross product.
  assign cross_abs = cross_r[32] ? -cross_r : cross_r;
  assign qsum      = {q1_r[32], q1_r} + {q2_r[32], q2_r};
  assign cross_ext = {{(AREA_W-33){cross_r[32]}}, cross_r};
  assign on_edge_hit = (cross_r == '0) &&
                       (ax_r <= 0 || bx_r <= 0) && (ax_r >= 0 || bx_r >= 0) &&
                       (ay_r <= 0 || by_r <= 0) && (ay_r >= 0 || by_r >= 0);
  assign par_hit = ((ay_r > 0) != (by_r > 0)) &&
                   ((dy_r > 0 && cross_r > 0) || (dy_r < 0 && cross_r < 0));

  // Closest point on the edge: an endpoint or the perpendicular foot.
  always_comb begin
    if (len2_r == '0 || proj_r <= 0) begin
      sel_num = NUM_W'(va_r);
      sel_den = DEN_W'(1);
    end else if (proj_r >= $signed({1'b0, len2_r})) begin
      sel_num = NUM_W'(vb_r);
      sel_den = DEN_W'(1);
    end else begin
      sel_num = cr2_r;
      sel_den = len2_r;
    end
  end

  assign div_t  = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign sq_sum = sr_r + sb_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      area_r      <= '0;
      par_r       <= 1'b0;
      onedge_r    <= 1'b0;
      best_num_r  <= '1;
      best_den_r  <= DEN_W'(1);
      maxn_r      <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            state_r <= S_NORM;
          end
        end
        // Fold the vertex into the norm maximum and pick the next edge.
        S_NORM: begin
          if (n2_cur > maxn_r) maxn_r <= n2_cur;
          if (seen_r == '0) begin
            first_x_r <= vx_r;
            first_y_r <= vy_r;
          end
          if (seen_r < MIN_VERTS) seen_r <= seen_r + 2'd1;
          prev_x_r <= vx_r;
          prev_y_r <= vy_r;
          if (seen_r != '0 || vl_r) begin
            state_r <= S_E1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_E1: state_r <= S_E2;
        S_E2: state_r <= S_E3;
        S_E3: begin
          area_r <= area_r + cross_ext;
          if (on_edge_hit) onedge_r <= 1'b1;
          if (par_hit) par_r <= ~par_r;
          state_r <= S_E4;
        end
        S_E4: state_r <= S_CMP;
        S_CMP: begin
          if (cnt_r == CNT_W'(DEN_W-1)) state_r <= S_UPD;
        end
        // Keep the smaller fraction, then close the polygon, finish or idle.
        S_UPD: begin
          if (acca_r < accb_r) begin
            best_num_r <= num_r;
            best_den_r <= den_r;
          end
          if (close_r) begin
            state_r <= S_FIN;
          end else if (vl_r) begin
            state_r <= S_E1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_FIN: state_r <= S_SQRT;
        S_SQRT: begin
          if (cnt_r == CNT_W'(NUM_W/2-1)) begin
            if (!sq_ins_r && ins_ok_r) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (cnt_r == CNT_W'(NUM_W-1)) state_r <= S_SQRT;
        end
        // Hand the result over and clear the polygon state.
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            seen_r      <= '0;
            area_r      <= '0;
            par_r       <= 1'b0;
            onedge_r    <= 1'b0;
            best_num_r  <= '1;
            best_den_r  <= DEN_W'(1);
            maxn_r      <= '0;
            first_x_r   <= '0;
            first_y_r   <= '0;
            prev_x_r    <= '0;
            prev_y_r    <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        vx_r <= q_item.x;
        vy_r <= q_item.y;
        vl_r <= q_item.last;
      end
      S_NORM: begin
        if (seen_r != '0) begin
          ax_r    <= prev_x_r;
          ay_r    <= prev_y_r;
          bx_r    <= vx_r;
          by_r    <= vy_r;
          close_r <= 1'b0;
        end else begin
          ax_r    <= vx_r;
          ay_r    <= vy_r;
          bx_r    <= vx_r;
          by_r    <= vy_r;
          close_r <= 1'b1;
        end
      end
      S_E1: begin
        p1_r <= ax_r * by_r;
        p2_r <= ay_r * bx_r;
        dx_r <= {bx_r[COORD_W-1], bx_r} - {ax_r[COORD_W-1], ax_r};
        dy_r <= {by_r[COORD_W-1], by_r} - {ay_r[COORD_W-1], ay_r};
      end
      S_E2: begin
        cross_r <= {p1_r[31], p1_r} - {p2_r[31], p2_r};
        q1_r    <= ax_r * dx_r;
        q2_r    <= ay_r * dy_r;
        s1_r    <= dx_r * dx_r;
        s2_r    <= dy_r * dy_r;
        va_r    <= va_full[NORM_W-1:0];
        vb_r    <= vb_full[NORM_W-1:0];
      end
      S_E3: begin
        cr2_r  <= cross_abs[31:0] * cross_abs[31:0];
        proj_r <= -{qsum[33], qsum};
        len2_r <= DEN_W'(s1_r + s2_r);
      end
      S_E4: begin
        num_r  <= sel_num;
        den_r  <= sel_den;
        mca_r  <= PROD_W'(sel_num);
        mpa_r  <= best_den_r;
        mcb_r  <= PROD_W'(best_num_r);
        mpb_r  <= sel_den;
        acca_r <= '0;
        accb_r <= '0;
        cnt_r  <= '0;
      end
      // One multiplier bit of each product per cycle.
      S_CMP: begin
        if (mpa_r[0]) acca_r <= acca_r + mca_r;
        if (mpb_r[0]) accb_r <= accb_r + mcb_r;
        mca_r <= mca_r << 1;
        mcb_r <= mcb_r << 1;
        mpa_r <= mpa_r >> 1;
        mpb_r <= mpb_r >> 1;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      S_UPD: begin
        if (!close_r && vl_r) begin
          ax_r    <= vx_r;
          ay_r    <= vy_r;
          bx_r    <= first_x_r;
          by_r    <= first_y_r;
          close_r <= 1'b1;
        end
      end
      S_FIN: begin
        circ_ok_r <= (seen_r == MIN_VERTS);
        ins_ok_r  <= (seen_r == MIN_VERTS) && (area_r != '0) && (par_r || onedge_r);
        sv_r      <= NUM_W'(maxn_r);
        sr_r      <= '0;
        sb_r      <= NUM_W'(1) << (NUM_W-2);
        sq_ins_r  <= 1'b0;
        cnt_r     <= '0;
      end
      // One result bit of the root per cycle.
      S_SQRT: begin
        if (sv_r >= sq_sum) begin
          sv_r <= sv_r - sq_sum;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
        if (cnt_r == CNT_W'(NUM_W/2-1)) begin
          cnt_r <= '0;
          if (!sq_ins_r) begin
            circ_res_r <= OUT_W'(sv_r >= sq_sum ? (sr_r >> 1) + sb_r : sr_r >> 1);
            quo_r      <= best_num_r;
            rem_r      <= '0;
          end
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      // Restoring divide, one quotient bit per cycle.
      S_DIV: begin
        if (div_t >= {1'b0, best_den_r}) begin
          rem_r <= div_t - {1'b0, best_den_r};
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= div_t;
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
        if (cnt_r == CNT_W'(NUM_W-1)) begin
          cnt_r    <= '0;
          sq_ins_r <= 1'b1;
          sv_r     <= {quo_r[NUM_W-2:0], div_t >= {1'b0, best_den_r}};
          sr_r     <= '0;
          sb_r     <= NUM_W'(1) << (NUM_W-2);
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      S_OUT: begin
        if (!out_valid_r) begin
          out_circ_r  <= circ_ok_r ? circ_res_r : '0;
          out_ins_r   <= (ins_ok_r && sq_ins_r) ? sr_r[OUT_W-1:0] : '0;
          out_insv_r  <= ins_ok_r;
          out_circv_r <= circ_ok_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Footprint radius testbench
// Streams polygon vertices into the block and checks each emitted pair of
// radii against a local bit-accurate prediction of the polygon accumulators.
// Directed shapes first, then random polygons under random idling and hold-offs.
// ----------------------------------------------------------------------------
module testbench;
  import fr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OUT_W-1:0] ins;
    logic [OUT_W-1:0] circ;
    logic             ins_ok;
    logic             circ_ok;
  } radii_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic signed [COORD_W-1:0] in_vertex_x;
  logic signed [COORD_W-1:0] in_vertex_y;
  logic in_last_vertex;
  logic empty;
  logic pop;
  logic [OUT_W-1:0] out_inscribed;
  logic [OUT_W-1:0] out_circumscribed;
  logic out_inscribed_valid;
  logic out_circumscribed_valid;

  radii_t pending_radii[$];
  int     error_count;
  int     idle_cycles;
  int     hold_cycles;
  bit     no_idle;

  // Polygon accumulators of the prediction.
  longint          first_x, first_y, prev_x, prev_y;
  int              seen;
  logic [39:0]     area_acc;
  bit              parity;
  bit              on_edge;
  logic [63:0]     best_num;
  logic [63:0]     best_den;
  logic [63:0]     max_norm;

  footprint_radii_top DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y),
    .in_last_vertex(in_last_vertex), .empty(empty), .pop(pop),
    .out_inscribed(out_inscribed), .out_circumscribed(out_circumscribed),
    .out_inscribed_valid(out_inscribed_valid),
    .out_circumscribed_valid(out_circumscribed_valid)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [63:0] square_of(longint v);
    longint a;
    a = (v < 0) ? -v : v;
    return a * a;
  endfunction

  // Bit-by-bit integer square root, truncated.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void clear_polygon();
    first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
    seen = 0;
    area_acc = '0;
    parity = 0;
    on_edge = 0;
    best_num = '1;
    best_den = 64'd1;
    max_norm = '0;
  endfunction

  // Fold one edge into area, crossing parity, on-edge flag and nearest distance.
  function automatic void fold_edge(longint ax, longint ay, longint bx, longint by);
    longint cross_p, dx, dy, proj;
    logic [63:0] len2, num, den;
    logic [127:0] lhs, rhs;
    cross_p = ax * by - ay * bx;
    dx = bx - ax;
    dy = by - ay;
    proj = -(ax * dx + ay * dy);
    len2 = square_of(dx) + square_of(dy);
    area_acc = area_acc + cross_p[39:0];
    if (cross_p == 0 && (ax <= 0 || bx <= 0) && (ax >= 0 || bx >= 0) &&
        (ay <= 0 || by <= 0) && (ay >= 0 || by >= 0))
      on_edge = 1;
    if ((ay > 0) != (by > 0)) begin
      if ((dy > 0 && cross_p > 0) || (dy < 0 && cross_p < 0)) parity = ~parity;
    end
    if (len2 == 0 || proj <= 0) begin
      num = square_of(ax) + square_of(ay);
      den = 1;
    end else if (proj >= longint'(len2)) begin
      num = square_of(bx) + square_of(by);
      den = 1;
    end else begin
      num = square_of(cross_p);
      den = len2;
    end
    lhs = 128'(num) * 128'(best_den);
    rhs = 128'(best_num) * 128'(den);
    if (lhs < rhs) begin
      best_num = num;
      best_den = den;
    end
  endfunction

  // Advance the prediction by one accepted vertex.
  function automatic void radii_predict(logic signed [COORD_W-1:0] vx,
                                        logic signed [COORD_W-1:0] vy, logic last);
    longint x, y;
    logic [63:0] n2;
    radii_t r;
    x = vx;
    y = vy;
    n2 = square_of(x) + square_of(y);
    if (seen == 0) begin
      first_x = x;
      first_y = y;
    end else begin
      fold_edge(prev_x, prev_y, x, y);
    end
    prev_x = x;
    prev_y = y;
    if (n2 > max_norm) max_norm = n2;
    if (seen < 3) seen++;
    if (last) begin
      fold_edge(x, y, first_x, first_y);
      r.circ_ok = (seen >= 3);
      r.ins_ok = r.circ_ok && area_acc != 0 && (parity || on_edge);
      r.circ = r.circ_ok ? OUT_W'(int_sqrt(max_norm)) : '0;
      r.ins = (r.ins_ok && best_den != 0) ? OUT_W'(int_sqrt(best_num / best_den)) : '0;
      pending_radii.push_back(r);
      clear_polygon();
    end
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Offer one vertex item and wait until the block takes it.
  task automatic send_vertex(logic signed [COORD_W-1:0] vx,
                             logic signed [COORD_W-1:0] vy, logic last);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_vertex_x <= vx;
    in_vertex_y <= vy;
    in_last_vertex <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    radii_predict(vx, vy, last);
  endtask

  // Random polygon: one vertex per quadrant in turn, so the origin is often inside.
  task automatic send_random_polygon();
    int n, q;
    logic signed [COORD_W-1:0] vx, vy;
    n = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
    q = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 2) begin
        vx = COORD_W'($urandom);
        vy = COORD_W'($urandom);
      end else begin
        vx = COORD_W'($urandom_range(32767, 1));
        vy = COORD_W'($urandom_range(32767, 1));
        if (q == 1 || q == 2) vx = -vx;
        if (q >= 2) vy = -vy;
        if ($urandom_range(7) == 0) vx = 0;
      end
      send_vertex(vx, vy, i == n - 1);
      q = (q + 1) % 4;
    end
  endtask

  // Result side: random stalls, long hold-offs on request, field-wise compare.
  int stall_left;
  always @(posedge clk) begin
    radii_t want;
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      if (pop && !empty) begin
        if (pending_radii.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          error_count++;
        end else begin
          want = pending_radii.pop_front();
          if (out_inscribed !== want.ins)
            report_mismatch("inscribed", out_inscribed, want.ins);
          if (out_circumscribed !== want.circ)
            report_mismatch("circumscribed", out_circumscribed, want.circ);
          if (out_inscribed_valid !== want.ins_ok)
            report_mismatch("inscribed_valid", out_inscribed_valid, want.ins_ok);
          if (out_circumscribed_valid !== want.circ_ok)
            report_mismatch("circumscribed_valid", out_circumscribed_valid,
                            want.circ_ok);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else if (no_idle) begin
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        stall_left = pick_gap();
        pop <= (stall_left == 0);
      end
    end
  end

  // Hand-picked shapes, including each degenerate case.
  task automatic test_directed();
    // Triangle around the origin.
    send_vertex(1024, 0, 0); send_vertex(-512, 1024, 0); send_vertex(-512, -1024, 1);
    // Square at the coordinate extremes.
    send_vertex(-32768, -32768, 0); send_vertex(32767, -32768, 0);
    send_vertex(32767, 32767, 0); send_vertex(-32768, 32767, 1);
    // Collinear points through the origin give zero area.
    send_vertex(-100, -100, 0); send_vertex(0, 0, 0); send_vertex(200, 200, 1);
    // Triangle away from the origin.
    send_vertex(1000, 1000, 0); send_vertex(2000, 1000, 0); send_vertex(1500, 3000, 1);
    // Origin lies on an edge.
    send_vertex(-500, 0, 0); send_vertex(500, 0, 0); send_vertex(0, 700, 1);
    // A lone last vertex, then a two-vertex polygon.
    send_vertex(-32768, 32767, 1);
    send_vertex(300, -300, 0); send_vertex(-300, 300, 1);
    // Repeated vertex makes a zero-length edge.
    send_vertex(800, -400, 0); send_vertex(800, -400, 0);
    send_vertex(-600, 900, 0); send_vertex(-700, -900, 1);
  endtask

  task automatic test_random(int vertices);
    int start;
    start = 0;
    while (start < vertices) begin
      no_idle = ($urandom_range(7) == 0);
      send_random_polygon();
      start += 5;
    end
    no_idle = 0;
  endtask

  // Receiver holds off for a long stretch while vertices keep coming.
  task automatic test_backpressure();
    hold_cycles = 1500;
    no_idle = 1;
    for (int i = 0; i < 8; i++) send_random_polygon();
    no_idle = 0;
  endtask

  // Sender pauses until every expected result has come back.
  task automatic test_drain_pause();
    push <= 1'b0;
    wait (pending_radii.size() == 0);
    @(posedge clk);
    for (int i = 0; i < 4; i++) send_random_polygon();
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_vertex_x = '0;
    in_vertex_y = '0;
    in_last_vertex = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    no_idle = 0;
    clear_polygon();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(350);
    test_backpressure();
    test_drain_pause();
    test_random(350);
    push <= 1'b0;
    wait (pending_radii.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_radii.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: footprint_radii_top.f
design/fr_pkg.sv
design/fr_front.sv
design/fr_engine.sv
design/footprint_radii_top.sv
dv/testbench.sv
